FILE: sv/tcsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsq_pkg
// Types and constants shared by the three-channel sample qualifier.
// ----------------------------------------------------------------------------
package tcsq_pkg;

    localparam int RAW_W      = 16;
    localparam int SCALE_W    = 32;
    localparam int FIX_W      = 48;
    localparam int BAND_W     = 47;
    localparam int LIMIT_W    = 16;
    localparam int TALLY_W    = 32;
    localparam int CHAN_W     = 2;
    localparam int RUN_W      = 2;
    localparam int MAX_TRIES  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // One attempt on the input word: ok flag, first read, second read.
    localparam int ATTEMPT_W    = 1 + 2 * RAW_W;
    localparam int IN_TDATA_W   = 104;
    localparam int OUT_TDATA_W  = 136;

    localparam logic signed [RAW_W:0] CURRENT_OFFSET = 17'sd2560;
    localparam logic [TALLY_W-1:0]    TALLY_MAX      = '1;

    localparam logic [SCALE_W-1:0] VOLT1_SCALE_RST   = 32'd5120;
    localparam logic [SCALE_W-1:0] VOLT2_SCALE_RST   = 32'd5120;
    localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = 32'd26214;
    localparam logic [FIX_W-1:0]   RECOVER_THR_RST   = 48'd63753421;
    localparam logic [LIMIT_W-1:0] PAIR_LIMIT_RST    = 16'd200;
    localparam logic [FIX_W-1:0]   VOLT_LOW_RST      = -48'sd1677722;
    localparam logic [FIX_W-1:0]   VOLT_HIGH_RST     = 48'd176160768;
    localparam logic [BAND_W-1:0]  ZERO_BAND_RST     = 47'd167772;

    typedef enum logic [CHAN_W-1:0] {
        CH_VOLT1   = 2'd0,
        CH_VOLT2   = 2'd1,
        CH_CURRENT = 2'd2
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLT1_SCALE   = 3'd0,
        REG_VOLT2_SCALE   = 3'd1,
        REG_CURRENT_SCALE = 3'd2,
        REG_RECOVER_THR   = 3'd3,
        REG_PAIR_LIMIT    = 3'd4,
        REG_VOLT_LOW      = 3'd5,
        REG_VOLT_HIGH     = 3'd6,
        REG_ZERO_BAND     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SCALE_W-1:0] volt1_scale;
        logic [SCALE_W-1:0] volt2_scale;
        logic [SCALE_W-1:0] current_scale;
        logic [FIX_W-1:0]   recover_threshold;
        logic [LIMIT_W-1:0] pair_diff_limit;
        logic [FIX_W-1:0]   volt_low_limit;
        logic [FIX_W-1:0]   volt_high_limit;
        logic [BAND_W-1:0]  zero_band;
    } cfg_t;

    // Word after qualification.
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              ok;
        logic [RAW_W-1:0]  raw;
    } qual_t;

    // Word after scaling.
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              ok;
        logic [RAW_W-1:0]  raw;
        logic [FIX_W-1:0]  prod;
    } scl_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic               updated;
        logic [RAW_W-1:0]   held_raw;
        logic [FIX_W-1:0]   scaled;
        logic               read_fault;
        logic [TALLY_W-1:0] fault_tally;
        logic               loop_broken;
        logic               current_fault;
        logic               volt1_fault;
        logic               volt2_fault;
        logic [TALLY_W-1:0] item_tally;
    } res_t;

endpackage
`default_nettype wire

FILE: sv/tcsq_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsq_lane
// Checks one read attempt: success flag and pair distance, plus the average.
// ----------------------------------------------------------------------------
module tcsq_lane (
    input  wire logic                        try_ok,
    input  wire logic [tcsq_pkg::RAW_W-1:0]  first,
    input  wire logic [tcsq_pkg::RAW_W-1:0]  second,
    input  wire logic [tcsq_pkg::LIMIT_W-1:0] limit,
    output logic                             hit,
    output logic [tcsq_pkg::RAW_W-1:0]       avg
);

    logic signed [tcsq_pkg::RAW_W:0] diff;
    logic signed [tcsq_pkg::RAW_W:0] sum;
    logic signed [tcsq_pkg::RAW_W:0] sum_adj;
    logic        [tcsq_pkg::RAW_W:0] mag;

    always_comb begin
        diff = $signed({first[tcsq_pkg::RAW_W-1], first})
             - $signed({second[tcsq_pkg::RAW_W-1], second});
        mag  = diff[tcsq_pkg::RAW_W] ? (tcsq_pkg::RAW_W+1)'(-diff)
                                     : (tcsq_pkg::RAW_W+1)'(diff);
        hit  = try_ok && (mag <= {1'b0, limit});

        // Halve with truncation toward zero: add one to a negative sum first.
        sum     = $signed({first[tcsq_pkg::RAW_W-1], first})
                + $signed({second[tcsq_pkg::RAW_W-1], second});
        sum_adj = sum + $signed({{tcsq_pkg::RAW_W{1'b0}}, sum[tcsq_pkg::RAW_W]});
        avg     = sum_adj[tcsq_pkg::RAW_W:1];
    end

endmodule
`default_nettype wire

FILE: sv/tcsq_qualify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsq_qualify
// Runs the attempt lanes side by side and keeps the first attempt that hit.
// ----------------------------------------------------------------------------
module tcsq_qualify #(
    parameter int LANES = 3
) (
    input  wire logic                                              aclk,
    input  wire logic                                              load,
    input  wire logic [tcsq_pkg::CHAN_W-1:0]                       chan,
    input  wire logic [tcsq_pkg::MAX_TRIES-1:0]                    try_ok,
    input  wire logic [tcsq_pkg::MAX_TRIES-1:0][tcsq_pkg::RAW_W-1:0] first,
    input  wire logic [tcsq_pkg::MAX_TRIES-1:0][tcsq_pkg::RAW_W-1:0] second,
    input  wire logic [tcsq_pkg::LIMIT_W-1:0]                      limit,
    output tcsq_pkg::qual_t                                        q_reg
);

    logic [LANES-1:0]                       hit;
    logic [LANES-1:0][tcsq_pkg::RAW_W-1:0]  avg;
    tcsq_pkg::qual_t                        q_next;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tcsq_lane u_lane (
            .try_ok (try_ok[k]),
            .first  (first[k]),
            .second (second[k]),
            .limit  (limit),
            .hit    (hit[k]),
            .avg    (avg[k])
        );
    end

    // Merge: the lowest attempt that hit wins, so scan from the top down.
    always_comb begin
        q_next.chan = chan;
        q_next.ok   = 1'b0;
        q_next.raw  = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (hit[k]) begin
                q_next.ok  = 1'b1;
                q_next.raw = avg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tcsq_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsq_scale
// Multiplies the qualified raw value by its channel's scale.
// ----------------------------------------------------------------------------
module tcsq_scale (
    input  wire logic                         aclk,
    input  wire logic                         load,
    input  wire tcsq_pkg::qual_t              q_in,
    input  wire logic [tcsq_pkg::SCALE_W-1:0] volt1_scale,
    input  wire logic [tcsq_pkg::SCALE_W-1:0] volt2_scale,
    input  wire logic [tcsq_pkg::SCALE_W-1:0] current_scale,
    output tcsq_pkg::scl_t                    s_reg
);

    logic signed [tcsq_pkg::RAW_W:0]           raw_ext;
    logic signed [tcsq_pkg::RAW_W:0]           opnd;
    logic        [tcsq_pkg::SCALE_W-1:0]       scale;
    logic signed [tcsq_pkg::RAW_W+tcsq_pkg::SCALE_W:0] prod;
    tcsq_pkg::scl_t                            s_next;

    always_comb begin
        raw_ext = $signed({q_in.raw[tcsq_pkg::RAW_W-1], q_in.raw});
        // The current loop is measured above its 4 mA offset.
        if (q_in.chan == tcsq_pkg::CH_CURRENT) begin
            opnd = raw_ext - tcsq_pkg::CURRENT_OFFSET;
        end else begin
            opnd = raw_ext;
        end
        unique case (q_in.chan)
            tcsq_pkg::CH_VOLT2:   scale = volt2_scale;
            tcsq_pkg::CH_CURRENT: scale = current_scale;
            default:              scale = volt1_scale;
        endcase
        prod        = opnd * $signed(scale);
        s_next.chan = q_in.chan;
        s_next.ok   = q_in.ok;
        s_next.raw  = q_in.raw;
        s_next.prod = prod[tcsq_pkg::FIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s_reg <= s_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tcsq_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsq_track
// Per-channel stores, fault flags, loop break hysteresis and the result word.
// ----------------------------------------------------------------------------
module tcsq_track #(
    parameter int CONFIRM_RUN = 3
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire tcsq_pkg::scl_t scl_in,
    input  wire tcsq_pkg::cfg_t cfg,
    output tcsq_pkg::res_t      res_reg
);

    localparam int RUN_EW = tcsq_pkg::RUN_W + 1;
    localparam logic [RUN_EW-1:0] RUN_CAP = RUN_EW'(CONFIRM_RUN);

    logic                          ever_valid_reg [3];
    logic                          ever_valid_next [3];
    logic                          last_fault_reg [3];
    logic                          last_fault_next [3];
    logic [tcsq_pkg::RAW_W-1:0]    raw_store_reg [3];
    logic [tcsq_pkg::RAW_W-1:0]    raw_store_next [3];
    logic [tcsq_pkg::FIX_W-1:0]    scaled_store_reg [3];
    logic [tcsq_pkg::FIX_W-1:0]    scaled_store_next [3];
    logic [tcsq_pkg::TALLY_W-1:0]  fault_cnt_reg [3];
    logic [tcsq_pkg::TALLY_W-1:0]  fault_cnt_next [3];
    logic [1:0]                    range_fault_reg;
    logic [1:0]                    range_fault_next;
    logic                          broken_reg;
    logic                          broken_next;
    logic [tcsq_pkg::RUN_W-1:0]    low_run_reg;
    logic [tcsq_pkg::RUN_W-1:0]    low_run_next;
    logic [tcsq_pkg::RUN_W-1:0]    high_run_reg;
    logic [tcsq_pkg::RUN_W-1:0]    high_run_next;
    logic [tcsq_pkg::TALLY_W-1:0]  items_reg;
    logic [tcsq_pkg::TALLY_W-1:0]  items_next;
    tcsq_pkg::res_t                res_next;

    logic [1:0]                    idx;
    logic signed [tcsq_pkg::FIX_W:0] v_ext;
    logic signed [tcsq_pkg::FIX_W:0] band_ext;
    logic                          in_band;
    logic [tcsq_pkg::FIX_W-1:0]    v_clamp;
    logic                          out_of_range;
    logic                          cur_low;
    logic                          cur_high;
    logic [RUN_EW-1:0]             low_inc;
    logic [RUN_EW-1:0]             high_inc;

    always_comb begin
        // A channel code of three cannot arise; it would be taken as voltage one.
        if (scl_in.chan == tcsq_pkg::CH_VOLT2 || scl_in.chan == tcsq_pkg::CH_CURRENT) begin
            idx = scl_in.chan;
        end else begin
            idx = tcsq_pkg::CH_VOLT1;
        end

        v_ext    = $signed({scl_in.prod[tcsq_pkg::FIX_W-1], scl_in.prod});
        band_ext = $signed({2'b00, cfg.zero_band});
        in_band  = (v_ext > -band_ext) && (v_ext < band_ext);
        v_clamp  = in_band ? '0 : scl_in.prod;
        out_of_range = ($signed(v_clamp) < $signed(cfg.volt_low_limit))
                    || ($signed(v_clamp) > $signed(cfg.volt_high_limit));
        cur_low  = $signed(scl_in.prod) < $signed(cfg.recover_threshold);
        cur_high = $signed(scl_in.prod) > $signed(cfg.recover_threshold);
        low_inc  = {1'b0, low_run_reg} + RUN_EW'(1);
        high_inc = {1'b0, high_run_reg} + RUN_EW'(1);

        ever_valid_next   = ever_valid_reg;
        last_fault_next   = last_fault_reg;
        raw_store_next    = raw_store_reg;
        scaled_store_next = scaled_store_reg;
        fault_cnt_next    = fault_cnt_reg;
        range_fault_next  = range_fault_reg;
        broken_next       = broken_reg;
        low_run_next      = low_run_reg;
        high_run_next     = high_run_reg;
        items_next        = items_reg + tcsq_pkg::TALLY_W'(1);

        if (scl_in.ok) begin
            raw_store_next[idx]  = scl_in.raw;
            ever_valid_next[idx] = 1'b1;
            last_fault_next[idx] = 1'b0;
            if (idx == tcsq_pkg::CH_CURRENT) begin
                scaled_store_next[idx] = scl_in.prod;
                // Break needs a run of low samples, recovery a run of high ones.
                if (!broken_reg) begin
                    if (cur_low) begin
                        if (low_inc >= RUN_CAP) begin
                            broken_next   = 1'b1;
                            low_run_next  = '0;
                            high_run_next = '0;
                        end else begin
                            low_run_next = low_inc[tcsq_pkg::RUN_W-1:0];
                        end
                    end else begin
                        low_run_next = '0;
                    end
                end else begin
                    if (cur_high) begin
                        if (high_inc >= RUN_CAP) begin
                            broken_next   = 1'b0;
                            low_run_next  = '0;
                            high_run_next = '0;
                        end else begin
                            high_run_next = high_inc[tcsq_pkg::RUN_W-1:0];
                        end
                    end else begin
                        high_run_next = '0;
                    end
                end
            end else begin
                scaled_store_next[idx]   = v_clamp;
                range_fault_next[idx[0]] = out_of_range;
            end
        end else begin
            last_fault_next[idx] = 1'b1;
            if (fault_cnt_reg[idx] != tcsq_pkg::TALLY_MAX) begin
                fault_cnt_next[idx] = fault_cnt_reg[idx] + tcsq_pkg::TALLY_W'(1);
            end
        end

        res_next.chan          = idx;
        res_next.updated       = scl_in.ok;
        res_next.held_raw      = raw_store_next[idx];
        res_next.scaled        = scaled_store_next[idx];
        res_next.read_fault    = !scl_in.ok;
        res_next.fault_tally   = fault_cnt_next[idx];
        res_next.loop_broken   = broken_next;
        res_next.current_fault = broken_next || last_fault_next[2] || !ever_valid_next[2];
        res_next.volt1_fault   = range_fault_next[0] || last_fault_next[0]
                              || !ever_valid_next[0];
        res_next.volt2_fault   = range_fault_next[1] || last_fault_next[1]
                              || !ever_valid_next[1];
        res_next.item_tally    = items_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                ever_valid_reg[i]   <= 1'b0;
                last_fault_reg[i]   <= 1'b0;
                raw_store_reg[i]    <= '0;
                scaled_store_reg[i] <= '0;
                fault_cnt_reg[i]    <= '0;
            end
            range_fault_reg <= '0;
            broken_reg      <= 1'b0;
            low_run_reg     <= '0;
            high_run_reg    <= '0;
            items_reg       <= '0;
        end else if (load) begin
            ever_valid_reg   <= ever_valid_next;
            last_fault_reg   <= last_fault_next;
            raw_store_reg    <= raw_store_next;
            scaled_store_reg <= scaled_store_next;
            fault_cnt_reg    <= fault_cnt_next;
            range_fault_reg  <= range_fault_next;
            broken_reg       <= broken_next;
            low_run_reg      <= low_run_next;
            high_run_reg     <= high_run_next;
            items_reg        <= items_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    // The break flag moves only on a qualified current sample.
    a_break_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(broken_reg)
        |-> $past(load && scl_in.ok && scl_in.chan == tcsq_pkg::CH_CURRENT))
        else $error("break flag changed without a qualified current sample");

endmodule
`default_nettype wire

FILE: sv/three_channel_sample_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_sample_qualifier
// Round-robin qualifier and scaler for two voltage channels and a 4-20 mA loop.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word, in
// order. Words are handed to voltage one, voltage two and current in turn,
// starting with voltage one after reset. The path is three registered stages:
// attempt lanes and first-hit merge, the 17 x 32 scaling multiplier, then the
// per-channel state update that feeds the output register. An accepted word
// moves from q_reg to s_reg and then to res_reg, where m_tvalid rises. Any
// stage that is empty or moving on accepts a new word, so up to three words
// are held while a result waits, and the input stalls only when all three
// stages are full behind a stalled output. The user must write configuration
// through cfg_we/cfg_addr/cfg_wdata only while idle; the block has no check.
// ----------------------------------------------------------------------------
module three_channel_sample_qualifier #(
    parameter int TRY_COUNT   = 3,
    parameter int CONFIRM_RUN = 3
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // try0_ok, try0_first, try0_second, try1_ok, try1_first, try1_second,
    // try2_ok, try2_first, try2_second, zero fill
    input  wire logic [tcsq_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // updated, held_raw, scaled, read_fault, fault_tally, loop_broken,
    // current_fault, volt1_fault, volt2_fault, item_tally, zero fill
    output logic [tcsq_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // chan
    output logic [tcsq_pkg::CHAN_W-1:0]               m_tuser,
    input  wire logic                                 cfg_we,
    input  wire logic [tcsq_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [tcsq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int LANES = (TRY_COUNT < tcsq_pkg::MAX_TRIES) ? TRY_COUNT
                                                             : tcsq_pkg::MAX_TRIES;

    tcsq_pkg::cfg_t  cfg_reg;
    tcsq_pkg::qual_t q_reg;
    tcsq_pkg::scl_t  s_reg;
    tcsq_pkg::res_t  res_reg;

    logic [tcsq_pkg::CHAN_W-1:0] chan_reg;
    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    logic                        m_valid_reg;
    logic                        out_ready;
    logic                        s2_ready;
    logic                        s1_load;
    logic                        s2_load;
    logic                        out_load;

    logic [tcsq_pkg::MAX_TRIES-1:0]                       try_ok;
    logic [tcsq_pkg::MAX_TRIES-1:0][tcsq_pkg::RAW_W-1:0]  try_first;
    logic [tcsq_pkg::MAX_TRIES-1:0][tcsq_pkg::RAW_W-1:0]  try_second;

    always_comb begin
        for (int k = 0; k < tcsq_pkg::MAX_TRIES; k++) begin
            try_ok[k]     = s_tdata[k*tcsq_pkg::ATTEMPT_W];
            try_first[k]  = s_tdata[k*tcsq_pkg::ATTEMPT_W+1 +: tcsq_pkg::RAW_W];
            try_second[k] = s_tdata[k*tcsq_pkg::ATTEMPT_W+1+tcsq_pkg::RAW_W
                                    +: tcsq_pkg::RAW_W];
        end
    end

    // Each stage takes a new word when it is empty or its word moves on.
    assign out_ready = !m_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s_tready  = !s1_valid_reg || s2_ready;
    assign s1_load   = s_tvalid && s_tready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign out_load  = s2_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            chan_reg     <= tcsq_pkg::CH_VOLT1;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (s1_load) begin
                if (chan_reg == tcsq_pkg::CH_CURRENT) begin
                    chan_reg <= tcsq_pkg::CH_VOLT1;
                end else begin
                    chan_reg <= chan_reg + tcsq_pkg::CHAN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volt1_scale       <= tcsq_pkg::VOLT1_SCALE_RST;
            cfg_reg.volt2_scale       <= tcsq_pkg::VOLT2_SCALE_RST;
            cfg_reg.current_scale     <= tcsq_pkg::CURRENT_SCALE_RST;
            cfg_reg.recover_threshold <= tcsq_pkg::RECOVER_THR_RST;
            cfg_reg.pair_diff_limit   <= tcsq_pkg::PAIR_LIMIT_RST;
            cfg_reg.volt_low_limit    <= tcsq_pkg::VOLT_LOW_RST;
            cfg_reg.volt_high_limit   <= tcsq_pkg::VOLT_HIGH_RST;
            cfg_reg.zero_band         <= tcsq_pkg::ZERO_BAND_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tcsq_pkg::REG_VOLT1_SCALE:
                    cfg_reg.volt1_scale <= cfg_wdata[tcsq_pkg::SCALE_W-1:0];
                tcsq_pkg::REG_VOLT2_SCALE:
                    cfg_reg.volt2_scale <= cfg_wdata[tcsq_pkg::SCALE_W-1:0];
                tcsq_pkg::REG_CURRENT_SCALE:
                    cfg_reg.current_scale <= cfg_wdata[tcsq_pkg::SCALE_W-1:0];
                tcsq_pkg::REG_RECOVER_THR:
                    cfg_reg.recover_threshold <= cfg_wdata[tcsq_pkg::FIX_W-1:0];
                tcsq_pkg::REG_PAIR_LIMIT:
                    cfg_reg.pair_diff_limit <= cfg_wdata[tcsq_pkg::LIMIT_W-1:0];
                tcsq_pkg::REG_VOLT_LOW:
                    cfg_reg.volt_low_limit <= cfg_wdata[tcsq_pkg::FIX_W-1:0];
                tcsq_pkg::REG_VOLT_HIGH:
                    cfg_reg.volt_high_limit <= cfg_wdata[tcsq_pkg::FIX_W-1:0];
                tcsq_pkg::REG_ZERO_BAND:
                    cfg_reg.zero_band <= cfg_wdata[tcsq_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    tcsq_qualify #(
        .LANES (LANES)
    ) u_qualify (
        .aclk   (aclk),
        .load   (s1_load),
        .chan   (chan_reg),
        .try_ok (try_ok),
        .first  (try_first),
        .second (try_second),
        .limit  (cfg_reg.pair_diff_limit),
        .q_reg  (q_reg)
    );

    tcsq_scale u_scale (
        .aclk          (aclk),
        .load          (s2_load),
        .q_in          (q_reg),
        .volt1_scale   (cfg_reg.volt1_scale),
        .volt2_scale   (cfg_reg.volt2_scale),
        .current_scale (cfg_reg.current_scale),
        .s_reg         (s_reg)
    );

    tcsq_track #(
        .CONFIRM_RUN (CONFIRM_RUN)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .scl_in  (s_reg),
        .cfg     (cfg_reg),
        .res_reg (res_reg)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.chan;
    assign m_tdata  = {2'b00,
                       res_reg.item_tally,
                       res_reg.volt2_fault,
                       res_reg.volt1_fault,
                       res_reg.current_fault,
                       res_reg.loop_broken,
                       res_reg.fault_tally,
                       res_reg.read_fault,
                       res_reg.scaled,
                       res_reg.held_raw,
                       res_reg.updated};

    // Input back-pressure only ever comes from a full pipe behind a stalled output.
    a_stall_cause: assert property (@(posedge aclk)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipe had room");

    // A failed current read must show as a current fault in the same word.
    a_current_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.chan == tcsq_pkg::CH_CURRENT && res_reg.read_fault)
        |-> res_reg.current_fault)
        else $error("current read fault without current fault flag");

endmodule
`default_nettype wire
